>>> design/apt_pkg.sv
package apt_pkg;

    // Number of presses averaged into a new period.
    localparam int HISTORY_DEPTH = 5;

    localparam int CNT_W    = 24;
    localparam int DEB_W    = 16;
    localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W    = CNT_W + $clog2(HISTORY_DEPTH);
    // Dividend of the rounded average is 2*sum + depth, divisor is 2*depth.
    localparam int DIVD_W   = SUM_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = CNT_W;

    // The rounded average equals (sum + HISTORY_DEPTH/2) / HISTORY_DEPTH. It is
    // taken as a product with the reciprocal rounded up, which is exact for every
    // sum below 2**SUM_W.
    localparam int RECIP_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1)
                 / 64'(HISTORY_DEPTH));
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(HISTORY_DEPTH / 2);

    localparam logic [CNT_W-1:0] CNT_MAX           = '1;
    localparam logic [CNT_W-1:0] INITIAL_PERIOD_RST = CNT_W'(468750);
    localparam logic [DEB_W-1:0] DEBOUNCE_LIMIT_RST = DEB_W'(2344);

    // Input kinds.
    localparam logic [1:0] KIND_PERIOD   = 2'd0;
    localparam logic [1:0] KIND_DEBOUNCE = 2'd1;
    localparam logic [1:0] KIND_PIN      = 2'd2;

    // Report codes.
    localparam logic [1:0] REPORT_NONE   = 2'd0;
    localparam logic [1:0] REPORT_PERIOD = 2'd1;
    localparam logic [1:0] REPORT_PRESS  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic       pressed;
    } apt_in_t;

    typedef struct packed {
        logic [1:0]       report;
        logic [CNT_W-1:0] current_period;
        logic             masked;
    } apt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul_step;
        logic load_period;
        logic emit;
    } apt_cmd_t;

    typedef struct packed {
        logic round_done;
    } apt_status_t;

endpackage

>>> design/apt_ctrl.sv
module apt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  apt_pkg::apt_status_t status,
    output apt_pkg::apt_cmd_t    cmd
);

    apt_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            apt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = apt_pkg::ST_EXEC;
                end
            end
            apt_pkg::ST_EXEC: begin
                if (status.round_done) begin
                    state_next = apt_pkg::ST_MUL;
                end else begin
                    state_next = apt_pkg::ST_EMIT;
                end
            end
            apt_pkg::ST_MUL: begin
                state_next = apt_pkg::ST_LOAD;
            end
            apt_pkg::ST_LOAD: begin
                state_next = apt_pkg::ST_EMIT;
            end
            apt_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = apt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            apt_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            apt_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            apt_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
            end
            apt_pkg::ST_LOAD: begin
                cmd.load_period = 1'b1;
            end
            apt_pkg::ST_EMIT: begin
                cmd.emit = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
        m_valid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> design/apt_datapath.sv
module apt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apt_pkg::CFG_W-1:0]       cfg_wdata,
    input  apt_pkg::apt_in_t                s_data,
    output apt_pkg::apt_out_t               m_data,
    input  apt_pkg::apt_cmd_t               cmd,
    output apt_pkg::apt_status_t            status
);

    apt_pkg::apt_in_t  item_reg;
    apt_pkg::apt_out_t m_data_reg;

    logic [apt_pkg::CNT_W-1:0]  period_count_reg, period_count_next;
    logic [apt_pkg::CNT_W-1:0]  ticks_reg, ticks_next;
    logic [apt_pkg::CNT_W-1:0]  period_reg;
    logic [apt_pkg::DEB_W-1:0]  limit_reg;
    logic [apt_pkg::DEB_W-1:0]  deb_count_reg, deb_count_next;
    logic                       active_reg, active_next;
    logic [apt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [apt_pkg::SUM_W-1:0]  sum_reg, sum_next, sum_added;
    logic [1:0]                 report_reg, report_next;

    logic [apt_pkg::CNT_W-1:0]  pc_inc;
    logic [apt_pkg::DEB_W-1:0]  dc_inc;
    logic                       round_done;

    // Rounded sum waiting for the reciprocal product, and the product itself.
    logic [apt_pkg::SUM_W-1:0]  avg_in_reg;
    logic [apt_pkg::PROD_W-1:0] prod_reg;

    // The history entries of one round are only ever read as a total, so the
    // round keeps a running sum instead of the individual entries.
    always_comb begin
        period_count_next = period_count_reg;
        ticks_next        = ticks_reg;
        deb_count_next    = deb_count_reg;
        active_next       = active_reg;
        slot_next         = slot_reg;
        sum_next          = sum_reg;
        report_next       = apt_pkg::REPORT_NONE;
        round_done        = 1'b0;
        pc_inc    = (period_count_reg == apt_pkg::CNT_MAX) ? period_count_reg
                                                            : period_count_reg + 1'b1;
        dc_inc    = deb_count_reg + 1'b1;
        sum_added = sum_reg + apt_pkg::SUM_W'(ticks_reg);
        case (item_reg.kind)
            apt_pkg::KIND_PERIOD: begin
                if (ticks_reg != apt_pkg::CNT_MAX) begin
                    ticks_next = ticks_reg + 1'b1;
                end
                period_count_next = pc_inc;
                if (pc_inc >= period_reg) begin
                    report_next       = apt_pkg::REPORT_PERIOD;
                    period_count_next = '0;
                end
            end
            apt_pkg::KIND_DEBOUNCE: begin
                if (active_reg) begin
                    deb_count_next = dc_inc;
                    if (dc_inc >= limit_reg || dc_inc == '0) begin
                        active_next    = 1'b0;
                        deb_count_next = '0;
                    end
                end
            end
            apt_pkg::KIND_PIN: begin
                if (!active_reg) begin
                    active_next    = 1'b1;
                    deb_count_next = '0;
                    if (item_reg.pressed) begin
                        report_next       = apt_pkg::REPORT_PRESS;
                        period_count_next = '0;
                        ticks_next        = '0;
                        if (slot_reg == apt_pkg::SLOT_W'(apt_pkg::HISTORY_DEPTH - 1)) begin
                            round_done = 1'b1;
                            slot_next  = '0;
                            sum_next   = '0;
                        end else begin
                            slot_next = slot_reg + 1'b1;
                            sum_next  = sum_added;
                        end
                    end
                end
            end
            default: begin
                report_next = apt_pkg::REPORT_NONE;
            end
        endcase
    end

    assign status.round_done = cmd.exec && round_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= '0;
            ticks_reg        <= '0;
            period_reg       <= apt_pkg::INITIAL_PERIOD_RST;
            limit_reg        <= apt_pkg::DEBOUNCE_LIMIT_RST;
            deb_count_reg    <= '0;
            active_reg       <= 1'b0;
            slot_reg         <= '0;
            sum_reg          <= '0;
            report_reg       <= apt_pkg::REPORT_NONE;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    apt_pkg::CFG_INITIAL_PERIOD: begin
                        period_reg <= cfg_wdata[apt_pkg::CNT_W-1:0];
                    end
                    apt_pkg::CFG_DEBOUNCE_LIMIT: begin
                        limit_reg <= cfg_wdata[apt_pkg::DEB_W-1:0];
                    end
                    default: begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
            if (cmd.exec) begin
                period_count_reg <= period_count_next;
                ticks_reg        <= ticks_next;
                deb_count_reg    <= deb_count_next;
                active_reg       <= active_next;
                slot_reg         <= slot_next;
                sum_reg          <= sum_next;
                report_reg       <= report_next;
            end
            if (cmd.load_period) begin
                period_reg <= prod_reg[apt_pkg::RECIP_SHIFT +: apt_pkg::CNT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            avg_in_reg <= sum_added + apt_pkg::ROUND_ADD;
        end
        if (cmd.mul_step) begin
            prod_reg <= apt_pkg::PROD_W'(avg_in_reg) * apt_pkg::PROD_W'(apt_pkg::RECIP);
        end
        if (cmd.emit) begin
            m_data_reg.report         <= report_reg;
            m_data_reg.current_period <= period_reg;
            m_data_reg.masked         <= active_reg;
        end
    end

    assign m_data = m_data_reg;

endmodule

>>> design/adaptive_period_timer_with_debounce.sv
// Adaptive period timer with button debounce.
// The input channel (s_valid, s_ready, s_data) carries one event per transfer:
// a period tick, a debounce tick or a pin change with the button level. For
// every input transfer exactly one result transfer follows on the output
// channel (m_valid, m_ready, m_data): the report code, the period in force
// after the event, and whether pin events are currently masked.
// The block works on one event at a time. An ordinary event passes through
// capture, update and output load. Every HISTORY_DEPTH-th accepted press also
// computes the new rounded average with a registered reciprocal multiplication
// and then loads it as the period. s_ready rises again once the result has
// moved into the output register, so a new event is taken while that result
// still waits; if the receiver stalls longer, the next result waits in the
// output load stage until the output register frees.
// The configuration port writes initial_period (index 0, also loading the
// period at once) and debounce_limit (index 1); the user must make writes only
// while the block is idle, as the block itself does not enforce it. A
// synchronous low aresetn restores the default period and debounce limit and
// clears all counters and m_valid; m_data is not reset.
module adaptive_period_timer_with_debounce (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  apt_pkg::apt_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output apt_pkg::apt_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [apt_pkg::CFG_W-1:0]     cfg_wdata
);

    apt_pkg::apt_cmd_t    cmd;
    apt_pkg::apt_status_t status;

    // The controller sequences each transfer; the datapath holds all counters.
    apt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

    // Only one event is in flight, so an input transfer closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an event is still in progress");

    // A press report always starts a debounce span.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.report == apt_pkg::REPORT_PRESS) |-> m_data.masked)
        else $error("press report without debounce masking");

    // Only the three defined report codes are ever produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.report == apt_pkg::REPORT_NONE ||
                     m_data.report == apt_pkg::REPORT_PERIOD ||
                     m_data.report == apt_pkg::REPORT_PRESS))
        else $error("undefined report code on the output");

    // The update stage is always followed by an output load or the averaging
    // steps, so the input stays closed through the update stage and the state after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 !s_ready)
        else $error("input reopened before the result was loaded");

endmodule
